### rtl/pcu_pkg.sv
// Package for the pixel component unpacker: field widths, stream packing,
// function and register codes, and the component mask helper.
// No dependencies.
package pcu_pkg;

    localparam int unsigned MAX_LINE_PIXELS_DEF = 4096;
    localparam int unsigned PALETTE_ENTRIES_DEF = 256;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FIRST_W = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned PIDX_W  = 8;
    localparam int unsigned PVAL_W  = 32;
    localparam int unsigned VALUE_W = 32;

    // input tdata layout, lowest field first
    localparam int unsigned DATA_LSB    = 0;
    localparam int unsigned FIRST_LSB   = DATA_LSB + BYTE_W;
    localparam int unsigned COUNT_LSB   = FIRST_LSB + FIRST_W;
    localparam int unsigned PIDX_LSB    = COUNT_LSB + COUNT_W;
    localparam int unsigned PVAL_LSB    = PIDX_LSB + PIDX_W;
    localparam int unsigned IN_FIELDS_W = PVAL_LSB + PVAL_W;
    localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned STEP_W     = 7;
    localparam int unsigned OFFSET_W   = 6;
    localparam int unsigned SHIFT_W    = 5;
    localparam int unsigned DEPTH_W    = 6;
    localparam int unsigned SEL_W      = 2;

    localparam int unsigned WINDOW_BYTES     = 8;
    localparam int unsigned FETCH_BYTES      = 5;
    localparam int unsigned RESULTS_PER_BYTE = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START  = 2'd0,
        FUNC_DATA   = 2'd1,
        FUNC_PAL_WR = 2'd2
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTES = 2'd0,
        MODE_BITS  = 2'd1,
        MODE_BE32  = 2'd2
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PACKING_MODE = 3'd0,
        REG_PIXEL_STEP   = 3'd1,
        REG_COMP_OFFSET  = 3'd2,
        REG_COMP_SHIFT   = 3'd3,
        REG_COMP_DEPTH   = 3'd4,
        REG_BIG_ENDIAN   = 3'd5,
        REG_USE_PALETTE  = 3'd6,
        REG_PAL_BYTE_SEL = 3'd7
    } t_reg_idx;

    function automatic logic [VALUE_W-1:0] depth_mask(input logic [DEPTH_W-1:0] d);
        logic [VALUE_W-1:0] m;
        if (d >= DEPTH_W'(VALUE_W)) begin
            m = '1;
        end else begin
            m = (VALUE_W'(1) << d[SHIFT_W-1:0]) - VALUE_W'(1);
        end
        return m;
    endfunction

endpackage

### rtl/pixel_component_unpacker_top.sv
// Pixel component unpacker top level: byte window, pixel extraction,
// palette memory and output register. Depends on pcu_pkg.
//
// Usage: the slave stream carries one item per transfer. tuser holds the
// function: start line (sets first pixel and pixel count, clears the byte
// window), line data byte, or palette entry write. Each data byte that
// completes pixels yields their component values on the master stream in
// order, tlast marking the last pixel of the line. Configuration is written
// through the plain write port while the block is idle.
// Throughput: one item per clock while the receiver accepts. A data byte that
// completes more than one pixel holds the input until its further pixels are
// out: the single extraction unit produces one pixel per cycle (at most eight
// per byte) while the output is free. A result passes the input register,
// then the output register with the palette read, to the master side.
// Reset clears the line state and loads the register defaults; palette
// contents stay undefined until written. When the receiver stalls, the
// result waits in the output register and one further item is still taken
// into the input register before tready falls.
module pixel_component_unpacker_top #(
    parameter int unsigned MAX_LINE_PIXELS = pcu_pkg::MAX_LINE_PIXELS_DEF,
    parameter int unsigned PALETTE_ENTRIES = pcu_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcu_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pcu_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // data_byte, first_pixel, pixel_count, palette_index, palette_value, zero fill
    input  logic [pcu_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // func
    input  logic [pcu_pkg::FUNC_W-1:0]         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // component_value
    output logic [pcu_pkg::VALUE_W-1:0]        o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);
    import pcu_pkg::*;

    localparam int unsigned MAX_STEP = 2**STEP_W - 1;
    localparam int unsigned SPAN     = (2**FIRST_W - 1) * MAX_STEP + 2**OFFSET_W
                                       + MAX_LINE_PIXELS * MAX_STEP + 2 * WINDOW_BYTES;
    localparam int unsigned POS_W    = $clog2(SPAN) + 1;
    localparam int unsigned BIT_W    = POS_W + 3;
    localparam int unsigned LEFT_W   = $clog2(MAX_LINE_PIXELS + 1);
    localparam int unsigned CNT_W    = $clog2(RESULTS_PER_BYTE);
    localparam int unsigned PAL_AW   = $clog2(PALETTE_ENTRIES);
    localparam int unsigned ADV_W    = STEP_W + 3;

    // configuration
    logic [MODE_W-1:0]   r_mode;
    logic [STEP_W-1:0]   r_step;
    logic [OFFSET_W-1:0] r_offset;
    logic [SHIFT_W-1:0]  r_shift;
    logic [DEPTH_W-1:0]  r_depth;
    logic                r_big_endian;
    logic                r_use_pal;
    logic [SEL_W-1:0]    r_pal_sel;

    // input register
    logic                r_in_valid;
    t_func               r_func;
    logic [BYTE_W-1:0]   r_byte;
    logic [FIRST_W-1:0]  r_first;
    logic [COUNT_W-1:0]  r_count;
    logic [PIDX_W-1:0]   r_pidx;
    logic [PVAL_W-1:0]   r_pval;
    logic                r_applied;
    logic [CNT_W-1:0]    r_cnt;

    // line state
    logic [POS_W-1:0]              r_pos;
    logic [8*WINDOW_BYTES-1:0]     r_win;
    logic [BIT_W-1:0]              r_bit;
    logic [LEFT_W-1:0]             r_left;

    // output register and palette
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_val;
    logic                r_out_last;
    logic                r_out_pal;
    logic                r_out_idx_ok;
    logic [SEL_W-1:0]    r_out_sel;
    logic [PVAL_W-1:0]   r_pal_q;
    logic [PVAL_W-1:0]   pal_mem [PALETTE_ENTRIES];

    t_mode                     mode;
    logic [8*WINDOW_BYTES-1:0] w_win;
    logic [POS_W-1:0]          w_pos;
    logic [DEPTH_W-1:0]        d_clip;
    logic [DEPTH_W:0]          sd;
    logic                      be_byte;
    logic [5:0]                ext;
    logic [ADV_W-1:0]          adv;
    logic [BIT_W:0]            last_bit;
    logic [BIT_W:0]            next_last_bit;
    logic                      ready_now;
    logic                      ready_next;
    logic [POS_W:0]            rd_byte;
    logic [POS_W:0]            back;
    logic [3:0]                bk;
    logic [FETCH_BYTES-1:0][7:0] rb;
    logic [8*FETCH_BYTES-1:0]  rb_be;
    logic [5:0]                bit_sh;
    logic [VALUE_W-1:0]        word;
    logic [VALUE_W-1:0]        mask;
    logic [VALUE_W-1:0]        a_val;
    logic                      a_want;
    logic                      a_emit;
    logic                      a_done;
    logic                      slot;
    logic [BIT_W-1:0]          start_bit;
    logic [FIRST_W+STEP_W-1:0] start_prod;
    logic [LEFT_W-1:0]         start_left;

    always_comb begin
        if (r_mode == MODE_BITS) begin
            mode = MODE_BITS;
        end else if (r_mode == MODE_BE32) begin
            mode = MODE_BE32;
        end else begin
            mode = MODE_BYTES;
        end
    end

    assign slot = !r_out_valid || i_m_axis_tready;

    // window as seen by the byte under work
    assign w_win = r_applied ? r_win : {r_win[8*WINDOW_BYTES-9:0], r_byte};
    assign w_pos = (r_applied || r_pos == '1) ? r_pos : r_pos + POS_W'(1);

    assign d_clip  = (r_depth > DEPTH_W'(VALUE_W)) ? DEPTH_W'(VALUE_W) : r_depth;
    assign sd      = {2'b00, r_shift} + {1'b0, r_depth};
    assign be_byte = (mode == MODE_BYTES) && (sd <= (DEPTH_W+1)'(8)) && r_big_endian;
    assign mask    = depth_mask(r_depth);

    // extent of the pixel in bits past its start, and advance per pixel
    always_comb begin
        case (mode)
            MODE_BITS: begin
                ext = (d_clip == '0) ? 6'd0 : d_clip - 6'd1;
                adv = ADV_W'(r_step);
            end
            MODE_BE32: begin
                ext = 6'd24;
                adv = ADV_W'(32);
            end
            default: begin
                if (sd <= (DEPTH_W+1)'(8)) begin
                    ext = be_byte ? 6'd8 : 6'd0;
                end else if (sd <= (DEPTH_W+1)'(16)) begin
                    ext = 6'd8;
                end else begin
                    ext = 6'd24;
                end
                adv = {r_step, 3'b000};
            end
        endcase
    end

    assign last_bit      = {1'b0, r_bit} + (BIT_W+1)'(ext);
    assign next_last_bit = last_bit + (BIT_W+1)'(adv);
    assign ready_now     = last_bit[BIT_W:3] < {1'b0, w_pos};
    assign ready_next    = next_last_bit[BIT_W:3] < {1'b0, w_pos};

    // bytes from the read start onwards, big-endian order, zero past the window
    assign rd_byte = {1'b0, r_bit[BIT_W-1:3]} + (POS_W+1)'(be_byte);
    assign back    = {1'b0, w_pos} - rd_byte - (POS_W+1)'(1);
    assign bk      = back[3:0];

    always_comb begin
        logic [3:0] bsel;
        logic       near;
        near = back < (POS_W+1)'(WINDOW_BYTES + FETCH_BYTES - 1);
        for (int i = 0; i < FETCH_BYTES; i++) begin
            bsel = bk - 4'(i);
            if (near && bk >= 4'(i) && bsel < 4'(WINDOW_BYTES)) begin
                rb[i] = w_win[{bsel[2:0], 3'b000} +: 8];
            end else begin
                rb[i] = 8'h00;
            end
        end
    end

    assign rb_be  = {rb[0], rb[1], rb[2], rb[3], rb[4]};
    assign bit_sh = 6'd40 - {3'b000, r_bit[2:0]} - d_clip;

    always_comb begin
        case (mode)
            MODE_BITS: begin
                word  = VALUE_W'(rb_be >> bit_sh);
                a_val = word & mask;
            end
            MODE_BE32: begin
                word  = {rb[0], rb[1], rb[2], rb[3]};
                a_val = (word >> r_offset) & mask;
            end
            default: begin
                if (sd <= (DEPTH_W+1)'(8)) begin
                    word = {24'h0, rb[0]};
                end else if (sd <= (DEPTH_W+1)'(16)) begin
                    word = r_big_endian ? {16'h0, rb[0], rb[1]} : {16'h0, rb[1], rb[0]};
                end else begin
                    word = r_big_endian ? {rb[0], rb[1], rb[2], rb[3]}
                                        : {rb[3], rb[2], rb[1], rb[0]};
                end
                a_val = (word >> r_shift) & mask;
            end
        endcase
    end

    // item control
    always_comb begin
        a_want = 1'b0;
        a_emit = 1'b0;
        a_done = 1'b1;
        case (r_func)
            FUNC_DATA: begin
                a_want = r_in_valid && (r_left != '0) && ready_now;
                a_emit = a_want && slot;
                if (a_want) begin
                    a_done = slot && (r_cnt == CNT_W'(RESULTS_PER_BYTE - 1)
                                      || r_left == LEFT_W'(1) || !ready_next);
                end
            end
            default: begin
                a_done = 1'b1;
            end
        endcase
    end

    assign o_s_axis_tready = !r_in_valid || a_done;

    assign start_prod = r_first * r_step;
    always_comb begin
        case (mode)
            MODE_BITS: start_bit = BIT_W'(start_prod) + BIT_W'(r_offset);
            MODE_BE32: start_bit = BIT_W'({r_first, 5'b00000});
            default:   start_bit = BIT_W'({BIT_W'(start_prod) + BIT_W'(r_offset), 3'b000});
        endcase
        if (32'(r_count) > 32'(MAX_LINE_PIXELS)) begin
            start_left = LEFT_W'(MAX_LINE_PIXELS);
        end else begin
            start_left = LEFT_W'(r_count);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_BYTES;
            r_step       <= STEP_W'(1);
            r_offset     <= '0;
            r_shift      <= '0;
            r_depth      <= DEPTH_W'(8);
            r_big_endian <= 1'b0;
            r_use_pal    <= 1'b0;
            r_pal_sel    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_PACKING_MODE: r_mode       <= i_cfg_wdata[MODE_W-1:0];
                REG_PIXEL_STEP:   r_step       <= i_cfg_wdata[STEP_W-1:0];
                REG_COMP_OFFSET:  r_offset     <= i_cfg_wdata[OFFSET_W-1:0];
                REG_COMP_SHIFT:   r_shift      <= i_cfg_wdata[SHIFT_W-1:0];
                REG_COMP_DEPTH:   r_depth      <= i_cfg_wdata[DEPTH_W-1:0];
                REG_BIG_ENDIAN:   r_big_endian <= i_cfg_wdata[0];
                REG_USE_PALETTE:  r_use_pal    <= i_cfg_wdata[0];
                REG_PAL_BYTE_SEL: r_pal_sel    <= i_cfg_wdata[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_func  <= t_func'(i_s_axis_tuser);
            r_byte  <= i_s_axis_tdata[DATA_LSB  +: BYTE_W];
            r_first <= i_s_axis_tdata[FIRST_LSB +: FIRST_W];
            r_count <= i_s_axis_tdata[COUNT_LSB +: COUNT_W];
            r_pidx  <= i_s_axis_tdata[PIDX_LSB  +: PIDX_W];
            r_pval  <= i_s_axis_tdata[PVAL_LSB  +: PVAL_W];
        end
    end

    // item and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_applied  <= 1'b0;
            r_cnt      <= '0;
            r_pos      <= '0;
            r_win      <= '0;
            r_bit      <= '0;
            r_left     <= '0;
        end else begin
            if (r_in_valid) begin
                case (r_func)
                    FUNC_START: begin
                        r_pos  <= '0;
                        r_win  <= '0;
                        r_bit  <= start_bit;
                        r_left <= start_left;
                    end
                    FUNC_DATA: begin
                        r_win     <= w_win;
                        r_pos     <= w_pos;
                        r_applied <= 1'b1;
                        if (a_emit) begin
                            r_left <= r_left - LEFT_W'(1);
                            r_bit  <= r_bit + BIT_W'(adv);
                            r_cnt  <= r_cnt + CNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
                r_applied  <= 1'b0;
                r_cnt      <= '0;
            end
        end
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (r_in_valid && r_func == FUNC_PAL_WR
                && {1'b0, r_pidx} < (PIDX_W+1)'(PALETTE_ENTRIES)) begin
            pal_mem[r_pidx[PAL_AW-1:0]] <= r_pval;
        end
        if (a_emit) begin
            r_pal_q <= pal_mem[a_val[PAL_AW-1:0]];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot) begin
            r_out_valid <= a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_emit) begin
            r_out_val    <= a_val;
            r_out_last   <= (r_left == LEFT_W'(1));
            r_out_pal    <= r_use_pal;
            r_out_idx_ok <= a_val < VALUE_W'(PALETTE_ENTRIES);
            r_out_sel    <= r_pal_sel;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = !r_out_pal    ? r_out_val :
                             r_out_idx_ok  ? {24'h0, r_pal_q[{r_out_sel, 3'b000} +: 8]} :
                                             '0;

    a_emit_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_emit |-> (!r_out_valid || i_m_axis_tready))
        else $error("pixel emitted while the output register is occupied");

    a_last_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_emit && r_left == LEFT_W'(1)) |=> (r_left == '0 && o_m_axis_tlast))
        else $error("last pixel of line not marked or count not cleared");

    a_budget : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_emit && r_cnt == CNT_W'(RESULTS_PER_BYTE - 1)) |-> o_s_axis_tready)
        else $error("more pixels than allowed for one byte");

    a_left_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= LEFT_W'(MAX_LINE_PIXELS))
        else $error("pixel count above line limit");

    a_hold_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_func == FUNC_DATA))
        else $error("input held without a data byte at work");

endmodule
